>>> hw/rtl/roid_enc_pkg.sv
// Package for the relative OID DER encoder: payload structs, sequencer
// states, encoding constants and the base-128 group selector.
// No dependencies.
package roid_enc_pkg;

  localparam int unsigned CONTENT_BYTES = 32;

  localparam logic [7:0] REL_OID_TAG = 8'h0D;
  localparam logic [6:0] GROUP_MASK  = 7'h7F;
  localparam logic [7:0] MORE_BIT    = 8'h80;

  typedef struct packed {
    logic [31:0] arc_value;
    logic        last_arc;
  } roid_enc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic       overflow;
  } roid_enc_out_t;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StEnc  = 5'b00010,
    StTag  = 5'b00100,
    StLen  = 5'b01000,
    StData = 5'b10000
  } roid_enc_state_e;

  // Index of the most significant non-zero 7-bit group (0 for a zero arc).
  function automatic logic [2:0] top_group(input logic [31:0] arc);
    logic [2:0] g;
    if (arc[31:28] != '0) begin
      g = 3'd4;
    end else if (arc[27:21] != '0) begin
      g = 3'd3;
    end else if (arc[20:14] != '0) begin
      g = 3'd2;
    end else if (arc[13:7] != '0) begin
      g = 3'd1;
    end else begin
      g = 3'd0;
    end
    return g;
  endfunction

  // Select 7-bit group number idx of the arc.
  function automatic logic [6:0] group_sel(input logic [31:0] arc, input logic [2:0] idx);
    logic [6:0] g;
    case (idx)
      3'd0:    g = arc[6:0];
      3'd1:    g = arc[13:7];
      3'd2:    g = arc[20:14];
      3'd3:    g = arc[27:21];
      3'd4:    g = {3'b000, arc[31:28]};
      default: g = '0;
    endcase
    return g & GROUP_MASK;
  endfunction

endpackage

>>> hw/rtl/relative_oid_der_encoder_core.sv
// Relative OID DER encoder top level: sequencer, group selector and content store.
// Depends on roid_enc_pkg.
//
// Usage:
//   Input: drive item_i and raise start; the arc is transferred at a rising edge
//   with start high and busy low. busy stays high while the arc is being
//   encoded and, for the final arc, while the encoding is sent out.
//   Output: each byte of the encoding appears on result_o for one cycle with
//   strobe_o high: tag 0x0D, the length byte, then the stored content bytes.
//   last_byte marks the final byte; overflow is set on every byte of a list
//   that lost content bytes because the store was full.
// Timing:
//   A non-final arc of G base-128 groups (G = 1..5) is taken in the transfer
//   cycle and then passes group by group through the shared group selector,
//   which writes one byte a cycle into the content store while it has room.
//   The final arc then adds the output (tag, length, N content bytes), one
//   byte a cycle, read through the single read port of the store.
// Reset: clears the sequencer, fill count and overflow flag; the store itself
//   is not cleared, only entries written in the current list are read.
// The receiver cannot stall: every strobed byte is taken.
module relative_oid_der_encoder_core #(
  parameter int unsigned CONTENT_BYTES = roid_enc_pkg::CONTENT_BYTES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  roid_enc_pkg::roid_enc_in_t  item_i,
  output logic                        strobe_o,
  output roid_enc_pkg::roid_enc_out_t result_o
);
  import roid_enc_pkg::*;

  localparam int unsigned AW = $clog2(CONTENT_BYTES);
  localparam int unsigned CW = $clog2(CONTENT_BYTES + 1);

  roid_enc_state_e state_q, state_d;
  logic [31:0]     arc_q, arc_d;
  logic            last_q, last_d;
  logic [2:0]      grp_q, grp_d;
  logic [CW-1:0]   fill_q, fill_d;
  logic            ovf_q, ovf_d;
  logic [CW-1:0]   idx_q, idx_d;

  logic [7:0]      mem [CONTENT_BYTES];
  logic [7:0]      rdata_q;
  logic [7:0]      enc_byte;
  logic            wr_en;
  logic            rd_en;
  logic [CW-1:0]   idx_next;
  logic [AW-1:0]   rd_addr;
  logic            data_last;

  assign enc_byte  = {(grp_q != 3'd0), group_sel(arc_q, grp_q)};
  assign idx_next  = idx_q + CW'(1);
  assign data_last = (idx_next == fill_q);
  assign wr_en     = (state_q == StEnc) && (fill_q < CW'(CONTENT_BYTES));

  always_comb begin
    state_d = state_q;
    arc_d   = arc_q;
    last_d  = last_q;
    grp_d   = grp_q;
    fill_d  = fill_q;
    ovf_d   = ovf_q;
    idx_d   = idx_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          arc_d   = item_i.arc_value;
          last_d  = item_i.last_arc;
          grp_d   = top_group(item_i.arc_value);
          state_d = StEnc;
        end
      end
      StEnc: begin
        if (wr_en) begin
          fill_d = fill_q + CW'(1);
        end else begin
          ovf_d = 1'b1;
        end
        if (grp_q == 3'd0) begin
          state_d = last_q ? StTag : StIdle;
        end else begin
          grp_d = grp_q - 3'd1;
        end
      end
      StTag: begin
        state_d = StLen;
      end
      StLen: begin
        // prefetch the first content byte
        rd_en   = 1'b1;
        rd_addr = '0;
        idx_d   = '0;
        if (fill_q == '0) begin
          state_d = StIdle;
          ovf_d   = 1'b0;
        end else begin
          state_d = StData;
        end
      end
      StData: begin
        if (data_last) begin
          state_d = StIdle;
          fill_d  = '0;
          ovf_d   = 1'b0;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_next[AW-1:0];
          idx_d   = idx_next;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      last_q  <= 1'b0;
      grp_q   <= '0;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
      grp_q   <= grp_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    arc_q <= arc_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[fill_q[AW-1:0]] <= enc_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign busy = (state_q != StIdle);

  always_comb begin
    strobe_o           = 1'b0;
    result_o.out_byte  = '0;
    result_o.last_byte = 1'b0;
    result_o.overflow  = ovf_q;
    case (state_q)
      StTag: begin
        strobe_o          = 1'b1;
        result_o.out_byte = REL_OID_TAG;
      end
      StLen: begin
        strobe_o           = 1'b1;
        result_o.out_byte  = 8'(fill_q);
        result_o.last_byte = (fill_q == '0);
      end
      StData: begin
        strobe_o           = 1'b1;
        result_o.out_byte  = rdata_q;
        result_o.last_byte = data_last;
      end
      default: begin
        strobe_o = 1'b0;
      end
    endcase
  end

  // Assertions
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(CONTENT_BYTES))
    else $error("fill count exceeds store size");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && result_o.last_byte |=> !busy && fill_q == '0 && !ovf_q)
    else $error("list state not cleared after final byte");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && result_o.overflow |-> fill_q == CW'(CONTENT_BYTES))
    else $error("overflow flagged with room left in store");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && state_q == StEnc)
    else $error("accepted arc did not start encoding");

  a_data_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StData |-> idx_q < fill_q)
    else $error("content read past fill count");

endmodule
